// ===== design/itst_pkg.sv =====
package itst_pkg;
    localparam int ENTRIES = 64;
    localparam int ID_W = 6;
    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int STAT_W = 32 + 64 + 64 + 64;
    localparam int STAMP_W = 64;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd1;
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_END = 1'b1;

    typedef struct packed {
        logic [31:0] calls;
        logic [63:0] total;
        logic [63:0] lo;
        logic [63:0] hi;
    } stats_t;
endpackage

// ===== design/itst_ram.sv =====
module itst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/itst_div.sv =====
module itst_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    import itst_pkg::*;

    logic [63:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] shifted;

    // one quotient bit a cycle, restoring
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg, quot_reg[63]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next  = 32'(shifted - {1'b0, dvs_reg});
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[31:0];
                quot_next = {quot_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = (cnt_reg != 7'd0);
    assign quotient = quot_reg;
endmodule

// ===== design/interval_timing_stats_table_top.sv =====
// channel  | dir | payload
// s_axis   | in  | tdata: func, entry_id, timestamp
// m_axis   | out | tdata: accepted, calls, total, min, max, avg
// cfg      | in  | index 0 enable, 1 active_entries
//
// an item passes through a read, a modify, a write-back that starts the
// radix-2 divider, the divider itself and the load of the output register,
// after which the result is valid. the statistics memories are cleared by a
// sweep over all ENTRIES addresses after reset; no item is taken meanwhile.
// no new item is taken until the result has left the output register, so a
// receiver stall also holds off the next item.
module interval_timing_stats_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // func, entry_id, timestamp, pad
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [295:0]  m_axis_tdata,   // accepted, calls, total, min, max, avg, pad
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [itst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]    cfg_data
);
    import itst_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [ADDR_W:0] clr_reg, clr_next;
    logic enable_reg;
    logic [6:0] active_reg;
    logic func_reg, ok_reg;
    logic [ADDR_W-1:0] id_reg;
    logic [63:0] stamp_reg;
    stats_t st_reg, st_next;
    logic out_valid_reg;
    logic [295:0] out_reg;

    // memories
    logic stamp_we, stat_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [63:0] stamp_wdata, stamp_rdata;
    stats_t stat_wdata, stat_rdata;
    logic [63:0] dur;
    logic div_start, div_busy;
    logic [63:0] quotient;
    logic in_ok;

    itst_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp (
        .clk(clk), .we(stamp_we), .waddr(waddr), .wdata(stamp_wdata),
        .raddr(raddr), .rdata(stamp_rdata));
    itst_ram #(.WIDTH(STAT_W), .DEPTH(ENTRIES)) u_stat (
        .clk(clk), .we(stat_we), .waddr(waddr), .wdata(stat_wdata),
        .raddr(raddr), .rdata(stat_rdata));
    itst_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(st_reg.total),
        .divisor(st_reg.calls), .busy(div_busy), .quotient(quotient));

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign raddr         = s_axis_tdata[ADDR_W:1];
    assign in_ok = enable_reg && ({1'b0, s_axis_tdata[6:1]} < active_reg);
    assign dur = stamp_reg - stamp_rdata;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        stamp_we    = 1'b0;
        stat_we     = 1'b0;
        waddr       = id_reg;
        stamp_wdata = stamp_reg;
        stat_wdata  = st_reg;
        st_next     = st_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                // sweep: start 0, stats reset values
                stamp_we    = 1'b1;
                stat_we     = 1'b1;
                waddr       = clr_reg[ADDR_W-1:0];
                stamp_wdata = '0;
                stat_wdata  = '{calls: '0, total: '0, lo: '1, hi: '0};
                clr_next    = clr_reg + (ADDR_W+1)'(1);
                if (clr_reg == (ADDR_W+1)'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                st_next = stat_rdata;
                if (ok_reg && func_reg == FUNC_START)
                begin
                    stamp_we = 1'b1;
                end
                else if (ok_reg && func_reg == FUNC_END)
                begin
                    if (stat_rdata.calls != '1)
                    begin
                        st_next.calls = stat_rdata.calls + 32'd1;
                    end
                    st_next.total = stat_rdata.total + dur;
                    if (dur < stat_rdata.lo)
                    begin
                        st_next.lo = dur;
                    end
                    if (dur > stat_rdata.hi)
                    begin
                        st_next.hi = dur;
                    end
                end
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                stat_we    = 1'b1;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            enable_reg    <= 1'b1;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                else if (cfg_index == REG_ACTIVE)
                begin
                    active_reg <= cfg_data;
                end
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg  <= s_axis_tdata[0];
            id_reg    <= s_axis_tdata[ADDR_W:1];
            stamp_reg <= s_axis_tdata[70:7];
            ok_reg    <= in_ok;
        end
        if (state_reg == ST_OUT)
        begin
            out_reg <= {7'd0,
                        (st_reg.calls == '0) ? 64'd0 : quotient,
                        st_reg.hi, st_reg.lo, st_reg.total, st_reg.calls, ok_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
endmodule

// ===== design/itst_checker.sv =====
module itst_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [295:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");
    a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32:1] != 32'd0 |->
        m_axis_tdata[160:97] <= m_axis_tdata[224:161])
        else $error("min above max");
    a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32:1] == 32'd0 |-> m_axis_tdata[288:225] == 64'd0)
        else $error("average without calls");
endmodule

bind interval_timing_stats_table_top itst_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

// ===== bench/interval_timing_stats_table_top_tb.sv =====
`timescale 1ns / 1ps

module interval_timing_stats_table_top_tb;
    import itst_pkg::*;

    localparam logic [63:0] ALL_ONES = '1;
    localparam int DRAIN_CYCLES = 160;

    typedef struct packed {
        logic [63:0] avg;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] total;
        logic [31:0] calls;
        logic        accepted;
    } timing_stats_t;

    typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic          reg_idx;
        logic [6:0]    reg_val;
        logic          func;
        logic [5:0]    id;
        logic [63:0]   stamp;
        bit            typed;
        timing_stats_t stats;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [295:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [6:0]   cfg_data;

    // shadow of the block's registers and per-entry records
    logic        shadow_enable;
    logic [6:0]  shadow_active;
    logic [63:0] start_mem [ENTRIES];
    logic [31:0] count_mem [ENTRIES];
    logic [63:0] sum_mem [ENTRIES];
    logic [63:0] short_mem [ENTRIES];
    logic [63:0] long_mem [ENTRIES];

    timing_stats_t pending_stats[$];
    stim_row_t     directed_rows[$];
    int errors;
    int events_sent;
    int stats_seen;
    int accepted_seen;
    bit quiet;
    bit hold_rx;

    interval_timing_stats_table_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %0s: got %h want %h (transfer %0d)", what, got, want, stats_seen);
    endtask

    // applies one event to the shadow table and returns the statistics it reports
    function automatic timing_stats_t apply_event(logic func, logic [5:0] id, logic [63:0] stamp);
        timing_stats_t r;
        logic [63:0] dur;
        r.accepted = shadow_enable && ({1'b0, id} < shadow_active);
        if (r.accepted)
        begin
            if (func == FUNC_START)
                start_mem[id] = stamp;
            else
            begin
                dur = stamp - start_mem[id];
                if (count_mem[id] != 32'hFFFF_FFFF)
                    count_mem[id]++;
                sum_mem[id] += dur;
                if (dur < short_mem[id])
                    short_mem[id] = dur;
                if (dur > long_mem[id])
                    long_mem[id] = dur;
            end
        end
        r.calls = count_mem[id];
        r.total = sum_mem[id];
        r.lo = short_mem[id];
        r.hi = long_mem[id];
        r.avg = (r.calls != 0) ? r.total / {32'd0, r.calls} : 64'd0;
        return r;
    endfunction

    task automatic send_event(logic func, logic [5:0] id, logic [63:0] stamp,
                              bit typed = 0, timing_stats_t typed_stats = '0);
        timing_stats_t p;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, stamp, id, func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        p = apply_event(func, id, stamp);
        pending_stats.push_back(typed ? typed_stats : p);
        events_sent++;
    endtask

    // register writes only once every result is out and the divider has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_ENABLE)
            shadow_enable = val[0];
        else
            shadow_active = val;
    endtask

    function automatic void add_event(logic func, logic [5:0] id, logic [63:0] stamp, bit typed,
                                      logic acc, logic [31:0] calls, logic [63:0] total,
                                      logic [63:0] lo, logic [63:0] hi, logic [63:0] avg);
        stim_row_t r;
        r.kind = ROW_EVENT;
        r.reg_idx = REG_ENABLE;
        r.reg_val = '0;
        r.func = func;
        r.id = id;
        r.stamp = stamp;
        r.typed = typed;
        r.stats = '{avg, hi, lo, total, calls, acc};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic idx, logic [6:0] val);
        stim_row_t r;
        r = '{ROW_REG, idx, val, FUNC_START, 6'd0, 64'd0, 1'b0, '0};
        directed_rows.push_back(r);
    endfunction

    // random event: mostly start/end pairs on a small pool of ids, some noise
    task automatic random_traffic(int n);
        logic [5:0] id;
        logic [63:0] t0;
        logic [63:0] dur;
        for (int i = 0; i < n; i++)
        begin
            id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 7));
            t0 = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: dur = {$urandom, $urandom};
                1: dur = 64'($urandom_range(0, 20));
                default: dur = 64'($urandom_range(0, 100000));
            endcase
            if ($urandom_range(0, 4) != 0)
            begin
                send_event(FUNC_START, id, t0);
                send_event(FUNC_END, id, t0 + dur);
                i++;
            end
            else
                send_event(logic'($urandom_range(0, 1)), id, t0);
        end
    endtask

    // receiver: random back-pressure bursts, plus one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker: oldest expectation first, field by field
    always @(posedge clk)
    begin
        timing_stats_t got;
        timing_stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[288:0];
            stats_seen++;
            if (pending_stats.size() == 0)
            begin
                errors++;
                $display("unexpected result transfer %0d", stats_seen);
            end
            else
            begin
                want = pending_stats.pop_front();
                if (got.accepted) accepted_seen++;
                if (got.accepted != want.accepted)
                    report("accepted", 64'(got.accepted), 64'(want.accepted));
                if (got.calls != want.calls)
                    report("calls", 64'(got.calls), 64'(want.calls));
                if (got.total != want.total) report("total_time", got.total, want.total);
                if (got.lo != want.lo) report("min_time", got.lo, want.lo);
                if (got.hi != want.hi) report("max_time", got.hi, want.hi);
                if (got.avg != want.avg) report("avg_time", got.avg, want.avg);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data = '0;
        errors = 0;
        events_sent = 0;
        stats_seen = 0;
        accepted_seen = 0;
        quiet = 0;
        hold_rx = 0;
        shadow_enable = 1'b1;
        shadow_active = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            start_mem[i] = '0;
            count_mem[i] = '0;
            sum_mem[i] = '0;
            short_mem[i] = ALL_ONES;
            long_mem[i] = '0;
        end

        // directed table: ignored after reset, wrap, end without start,
        // total wrap, inactive id, disabled, oversized active count
        add_event(FUNC_START, 6'd0, 64'd0, 1, 0, 0, 0, ALL_ONES, 0, 0);
        add_reg(REG_ACTIVE, 7'd64);
        add_event(FUNC_START, 6'd63, ALL_ONES, 1, 1, 0, 0, ALL_ONES, 0, 0);
        add_event(FUNC_END, 6'd63, 64'd5, 1, 1, 1, 6, 6, 6, 6);
        add_event(FUNC_END, 6'd5, 64'd100, 1, 1, 1, 100, 100, 100, 100);
        add_event(FUNC_END, 6'd5, 64'd40, 1, 1, 2, 140, 40, 100, 70);
        add_event(FUNC_START, 6'd0, 64'd0, 1, 1, 0, 0, ALL_ONES, 0, 0);
        add_event(FUNC_END, 6'd0, ALL_ONES, 1, 1, 1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        add_event(FUNC_END, 6'd0, 64'd1, 1, 1, 2, 0, 1, ALL_ONES, 0);
        add_event(FUNC_START, 6'd42, 64'h5555_AAAA_5555_AAAA, 0, 0, 0, 0, 0, 0, 0);
        add_event(FUNC_END, 6'd42, 64'hAAAA_5555_AAAA_5555, 0, 0, 0, 0, 0, 0, 0);
        add_reg(REG_ACTIVE, 7'd6);
        add_event(FUNC_END, 6'd6, 64'd9, 1, 0, 0, 0, ALL_ONES, 0, 0);
        add_event(FUNC_END, 6'd5, 64'd7, 1, 1, 3, 147, 7, 100, 49);
        add_reg(REG_ENABLE, 7'd0);
        add_event(FUNC_END, 6'd5, 64'd500, 1, 0, 3, 147, 7, 100, 49);
        add_event(FUNC_START, 6'd1, 64'd3, 1, 0, 0, 0, ALL_ONES, 0, 0);
        add_reg(REG_ENABLE, 7'd1);
        add_reg(REG_ACTIVE, 7'd127);
        add_event(FUNC_END, 6'd33, 64'd3, 1, 1, 1, 3, 3, 3, 3);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_event(directed_rows[i].func, directed_rows[i].id, directed_rows[i].stamp,
                           directed_rows[i].typed, directed_rows[i].stats);
        end

        // random phases across register settings
        write_reg(REG_ACTIVE, 7'd64);
        random_traffic(200);
        hold_rx = 1;                // receiver holds off while items keep coming
        random_traffic(100);
        wait_idle();                // sender pauses until everything is out
        random_traffic(60);
        write_reg(REG_ACTIVE, 7'd5);
        random_traffic(120);
        write_reg(REG_ACTIVE, 7'd0);
        random_traffic(40);
        write_reg(REG_ACTIVE, 7'd127);
        write_reg(REG_ENABLE, 7'd0);
        random_traffic(60);
        write_reg(REG_ENABLE, 7'd1);
        write_reg(REG_ACTIVE, 7'd1);
        random_traffic(60);
        write_reg(REG_ACTIVE, 7'd64);
        quiet = 1;                  // no idling on either side from here on
        random_traffic(260);

        s_axis_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d events, %0d results checked, %0d accepted, over 7 register settings",
                 events_sent, stats_seen, accepted_seen);
        if (errors == 0 && pending_stats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== sim.f =====
design/itst_pkg.sv
design/itst_ram.sv
design/itst_div.sv
design/interval_timing_stats_table_top.sv
design/itst_checker.sv
bench/interval_timing_stats_table_top_tb.sv
